[hdl/status_led_pattern_generator_defines.svh]
// Assertion macros shared by the status LED pattern generator RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH
`define STATUS_LED_PATTERN_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLEDPG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sledpg: check failed");

// Next-cycle implication, disabled during reset.
`define SLEDPG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sledpg: check failed");

`endif

[hdl/sledpg_pkg.sv]
// Package for the status LED pattern generator: timing constants, codes,
// word layouts and small helper functions. No dependencies.
package sledpg_pkg;

   localparam int MAX_COUNT_PULSES = 6;
   localparam int RESET_BLINKS     = 20;

   localparam int HB_PERIOD_MS     = 10000;
   localparam int HB_PULSE_MS      = 25;
   localparam int TRAFFIC_PULSE_MS = 50;
   localparam int CNT_ON_MS        = 300;
   localparam int CNT_GAP_MS       = 200;
   localparam int CNT_SLOT_MS      = CNT_ON_MS + CNT_GAP_MS;
   localparam int CNT_WINDOW_MS    = 3000;
   localparam int FAST_HALF_MS     = 50;
   localparam int SLOW_HALF_MS     = 500;
   localparam int RESET_SLOT_MS    = 100;
   localparam int RESET_ON_MS      = 50;
   localparam int BAT_LEAD_MS      = 1000;
   localparam int BAT_TAIL_MS      = 2000;
   localparam int BAT_LOW_PCT      = 10;
   localparam int BAT_LOW_ON_MS    = 100;
   localparam int BAT_LOW_BODY_MS  = 300;
   localparam int BAT_MAX_PULSES   = 4;

   localparam int RESET_SEQ_MS = RESET_BLINKS * RESET_SLOT_MS;
   localparam int BAT_SEQ_MS   = BAT_LEAD_MS + BAT_MAX_PULSES * CNT_SLOT_MS + BAT_TAIL_MS;
   localparam int SEQ_MAX_MS   = (RESET_SEQ_MS > BAT_SEQ_MS) ? RESET_SEQ_MS : BAT_SEQ_MS;
   // elapsed time of a running sequence always stays below SEQ_MAX_MS
   localparam int ELAPSED_W    = $clog2(SEQ_MAX_MS);
   localparam int CNT_W        = $clog2(MAX_COUNT_PULSES + 1);
   localparam int PHASE_W      = $clog2(CNT_WINDOW_MS);
   localparam int SLOT_REM_W   = $clog2(RESET_SLOT_MS);

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_LED_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HB_ENABLE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LOW = 2'd2;

   localparam logic [2:0] MODE_TRAFFIC = 3'd0;
   localparam logic [2:0] MODE_BLE     = 3'd1;
   localparam logic [2:0] MODE_TCP     = 3'd2;
   localparam logic [2:0] MODE_STA     = 3'd3;
   localparam logic [2:0] MODE_AP      = 3'd4;

   localparam logic [1:0] BLE_OFF         = 2'd0;
   localparam logic [1:0] BLE_ADVERTISING = 2'd1;
   localparam logic [1:0] BLE_PAIRING     = 2'd2;
   localparam logic [1:0] BLE_CONNECTED   = 2'd3;

   typedef enum logic [1:0] {
      SEQ_NONE    = 2'd0,
      SEQ_BATTERY = 2'd1,
      SEQ_RESET   = 2'd2
   } seq_kind_type;

   // input word, lowest field last
   typedef struct packed {
      logic [2:0]  spare;
      logic        reset_request;
      logic [6:0]  battery_percent;
      logic        battery_request;
      logic        traffic_seen;
      logic [7:0]  ap_stations;
      logic        sta_connected;
      logic [7:0]  proxy_clients;
      logic [1:0]  ble_state;
      logic [31:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic [5:0] spare;
      logic       sequence_busy;
      logic       led_pin;
   } rsp_word_type;

   // per-word context carried down the pipeline
   typedef struct packed {
      seq_kind_type         seq_kind;
      logic [6:0]           seq_percent;
      logic [ELAPSED_W-1:0] elapsed;
      logic [1:0]           ble_state;
      logic                 proxy_active;
      logic                 sta_connected;
      logic [CNT_W-1:0]     ap_count;
      logic                 heartbeat_on;
      logic                 traffic_on;
      logic                 normal_on;
   } led_ctx_type;

   function automatic logic [2:0] battery_pulses(input logic [6:0] pct);
      logic [2:0] n;
      priority if (pct < 7'd25) n = 3'd1;
      else if (pct < 7'd50)     n = 3'd2;
      else if (pct < 7'd75)     n = 3'd3;
      else                      n = 3'd4;
      return n;
   endfunction

   function automatic logic [31:0] seq_length(input seq_kind_type kind, input logic [6:0] pct);
      logic [31:0] body;
      body = (pct < 7'(BAT_LOW_PCT)) ? 32'(BAT_LOW_BODY_MS)
                                     : 32'(battery_pulses(pct)) * 32'(CNT_SLOT_MS);
      if (kind == SEQ_RESET)
         return 32'(RESET_SEQ_MS);
      return 32'(BAT_LEAD_MS) + body + 32'(BAT_TAIL_MS);
   endfunction

   // pulse active while 0 < (until - now) < 2^31, modulo 2^32
   function automatic logic window_open(input logic [31:0] until_ms, input logic [31:0] now_ms);
      logic [31:0] d;
      d = until_ms - now_ms;
      return (d != 32'd0) && !d[31];
   endfunction

endpackage

[hdl/status_led_pattern_generator.sv]
// Status LED pattern generator: per-tick LED level from mode, link status,
// heartbeat, traffic and battery/reset sequences. Uses sledpg_pkg, sledpg_cdiv.
//
// One word is taken every clock cycle. There are five register stages: input
// register, state update, blink phase divider, sequence phase divider, result
// register; the constant dividers take two stages each. Sequence and pulse
// state is updated as a word leaves the input register, so successive words
// see each other's effects exactly in order. A stalled result stalls the whole
// pipeline. Configuration registers are written through the csr_ port; the user
// must do so only while no word is in flight; the block does not enforce this.
`include "status_led_pattern_generator_defines.svh"

module status_led_pattern_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms[31:0], ble_state[33:32], proxy_clients[41:34], sta_connected[42],
   // ap_stations[50:43], traffic_seen[51], battery_request[52],
   // battery_percent[59:53], reset_request[60], zero[63:61]
   input  logic [sledpg_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // led_pin[0], sequence_busy[1], zero[7:2]
   output logic [sledpg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                                csr_we,
   input  logic [sledpg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sledpg_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import sledpg_pkg::*;

   // configuration
   logic [2:0] led_mode_ff, led_mode_in;
   logic       hb_enable_ff, hb_enable_in;
   logic       active_low_ff, active_low_in;

   // pipeline control
   logic         adv;
   logic         state_step;
   logic         a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   req_word_type a_word_ff;
   logic [31:0]  now;
   led_ctx_type  b_ctx_ff, b_ctx_in;
   led_ctx_type  c_ctx_ff;
   led_ctx_type  d_ctx_ff, d_ctx_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // sequence and pulse state
   seq_kind_type seq_kind_ff, seq_kind_in;
   logic [31:0]  seq_start_ff, seq_start_in;
   logic [6:0]   seq_pct_ff, seq_pct_in;
   logic         bat_pend_ff, bat_pend_in;
   logic [6:0]   pend_pct_ff, pend_pct_in;
   logic         reset_pend_ff, reset_pend_in;
   logic         traffic_pend_ff, traffic_pend_in;
   logic [31:0]  hb_ref_ff, hb_ref_in;
   logic [31:0]  hb_until_ff, hb_until_in;
   logic [31:0]  traffic_until_ff, traffic_until_in;
   logic         started_ff;
   logic [31:0]  seq_elapsed;
   logic         seq_fresh;
   logic         hb_due;
   logic         hb_on;
   logic         traffic_on;

   // divider results
   logic                  fast_odd;
   logic                  slow_odd;
   logic [PHASE_W-1:0]    cnt_phase;
   logic [SLOT_REM_W-1:0] reset_phase;

   logic count_on;
   logic mode_on;
   logic seq_on;
   logic [2:0] bat_pulses;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign state_step = adv && a_valid_ff;
   assign now        = a_word_ff.now_ms;

   // ---------------- configuration port ----------------
   always_comb begin
      led_mode_in   = led_mode_ff;
      hb_enable_in  = hb_enable_ff;
      active_low_in = active_low_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LED_MODE:   led_mode_in   = csr_wdata[2:0];
            CSR_HB_ENABLE:  hb_enable_in  = csr_wdata[0];
            CSR_ACTIVE_LOW: active_low_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_mode_ff   <= MODE_TRAFFIC;
         hb_enable_ff  <= 1'b0;
         active_low_ff <= 1'b0;
      end else begin
         led_mode_ff   <= led_mode_in;
         hb_enable_ff  <= hb_enable_in;
         active_low_ff <= active_low_in;
      end
   end

   // ---------------- valid chain ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= req_tvalid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_word_ff   <= req_word_type'(req_tdata);
         b_ctx_ff    <= b_ctx_in;
         c_ctx_ff    <= b_ctx_ff;
         d_ctx_ff    <= d_ctx_in;
         rsp_word_ff <= rsp_word_in;
      end
   end

   // ---------------- state update ----------------
   always_comb begin
      reset_pend_in    = reset_pend_ff | a_word_ff.reset_request;
      bat_pend_in      = bat_pend_ff | a_word_ff.battery_request;
      pend_pct_in      = a_word_ff.battery_request ? a_word_ff.battery_percent : pend_pct_ff;
      traffic_pend_in  = traffic_pend_ff | a_word_ff.traffic_seen;
      // first word loads the timers so no pulse is active
      hb_ref_in        = started_ff ? hb_ref_ff : now;
      hb_until_in      = started_ff ? hb_until_ff : now;
      traffic_until_in = started_ff ? traffic_until_ff : now;
      seq_kind_in      = seq_kind_ff;
      seq_start_in     = seq_start_ff;
      seq_pct_in       = seq_pct_ff;
      seq_elapsed      = now - seq_start_ff;
      seq_fresh        = 1'b0;
      hb_due           = 1'b0;
      hb_on            = 1'b0;
      traffic_on       = 1'b0;

      if (seq_kind_ff != SEQ_NONE && seq_elapsed >= seq_length(seq_kind_ff, seq_pct_ff))
         seq_kind_in = SEQ_NONE;

      if (seq_kind_in == SEQ_NONE) begin
         priority if (reset_pend_in) begin
            reset_pend_in = 1'b0;
            seq_kind_in   = SEQ_RESET;
            seq_start_in  = now;
            seq_fresh     = 1'b1;
         end else if (bat_pend_in) begin
            bat_pend_in  = 1'b0;
            seq_kind_in  = SEQ_BATTERY;
            seq_pct_in   = pend_pct_in;
            seq_start_in = now;
            seq_fresh    = 1'b1;
         end else begin
         end
      end

      if (seq_kind_in == SEQ_NONE) begin
         if (hb_enable_ff) begin
            hb_due = (now - hb_ref_in) >= 32'(HB_PERIOD_MS);
            hb_on  = hb_due || window_open(hb_until_in, now);
            if (hb_due) begin
               hb_ref_in   = now;
               hb_until_in = now + 32'(HB_PULSE_MS);
            end
         end
         traffic_on = traffic_pend_in || window_open(traffic_until_in, now);
         if (traffic_pend_in) begin
            traffic_until_in = now + 32'(TRAFFIC_PULSE_MS);
            traffic_pend_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_kind_ff      <= SEQ_NONE;
         seq_start_ff     <= '0;
         seq_pct_ff       <= '0;
         bat_pend_ff      <= 1'b0;
         pend_pct_ff      <= '0;
         reset_pend_ff    <= 1'b0;
         traffic_pend_ff  <= 1'b0;
         hb_ref_ff        <= '0;
         hb_until_ff      <= '0;
         traffic_until_ff <= '0;
         started_ff       <= 1'b0;
      end else if (state_step) begin
         seq_kind_ff      <= seq_kind_in;
         seq_start_ff     <= seq_start_in;
         seq_pct_ff       <= seq_pct_in;
         bat_pend_ff      <= bat_pend_in;
         pend_pct_ff      <= pend_pct_in;
         reset_pend_ff    <= reset_pend_in;
         traffic_pend_ff  <= traffic_pend_in;
         hb_ref_ff        <= hb_ref_in;
         hb_until_ff      <= hb_until_in;
         traffic_until_ff <= traffic_until_in;
         started_ff       <= 1'b1;
      end
   end

   always_comb begin
      b_ctx_in               = '0;
      b_ctx_in.seq_kind      = seq_kind_in;
      b_ctx_in.seq_percent   = seq_pct_in;
      b_ctx_in.elapsed       = seq_fresh ? '0 : seq_elapsed[ELAPSED_W-1:0];
      b_ctx_in.ble_state     = a_word_ff.ble_state;
      b_ctx_in.proxy_active  = a_word_ff.proxy_clients != 8'd0;
      b_ctx_in.sta_connected = a_word_ff.sta_connected;
      b_ctx_in.ap_count      = (a_word_ff.ap_stations > 8'(MAX_COUNT_PULSES))
                               ? CNT_W'(MAX_COUNT_PULSES) : a_word_ff.ap_stations[CNT_W-1:0];
      b_ctx_in.heartbeat_on  = hb_on;
      b_ctx_in.traffic_on    = traffic_on;
   end

   // ---------------- blink phase dividers ----------------
   sledpg_cdiv #(.WIDTH(32), .DIVISOR(FAST_HALF_MS)) u_div_fast (
      .clock        (clock),
      .enable       (adv),
      .dividend     (now),
      .quotient_odd (fast_odd),
      .remainder    ()
   );

   sledpg_cdiv #(.WIDTH(32), .DIVISOR(SLOW_HALF_MS)) u_div_slow (
      .clock        (clock),
      .enable       (adv),
      .dividend     (now),
      .quotient_odd (slow_odd),
      .remainder    ()
   );

   sledpg_cdiv #(.WIDTH(32), .DIVISOR(CNT_WINDOW_MS)) u_div_window (
      .clock        (clock),
      .enable       (adv),
      .dividend     (now),
      .quotient_odd (),
      .remainder    (cnt_phase)
   );

   sledpg_cdiv #(.WIDTH(ELAPSED_W), .DIVISOR(RESET_SLOT_MS)) u_div_seq (
      .clock        (clock),
      .enable       (adv),
      .dividend     (b_ctx_ff.elapsed),
      .quotient_odd (),
      .remainder    (reset_phase)
   );

   // ---------------- mode pattern ----------------
   always_comb begin
      count_on = 1'b0;
      for (int k = 0; k < MAX_COUNT_PULSES; k++) begin
         if (CNT_W'(k) < c_ctx_ff.ap_count
             && cnt_phase >= PHASE_W'(k * CNT_SLOT_MS)
             && cnt_phase < PHASE_W'(k * CNT_SLOT_MS + CNT_ON_MS))
            count_on = 1'b1;
      end
   end

   always_comb begin
      mode_on = 1'b0;
      unique case (led_mode_ff)
         MODE_BLE: begin
            unique case (c_ctx_ff.ble_state)
               BLE_CONNECTED:   mode_on = 1'b1;
               BLE_PAIRING:     mode_on = fast_odd;
               BLE_ADVERTISING: mode_on = slow_odd;
               BLE_OFF:         mode_on = 1'b0;
            endcase
         end
         MODE_TCP: mode_on = c_ctx_ff.proxy_active;
         MODE_STA: mode_on = c_ctx_ff.sta_connected || slow_odd;
         MODE_AP:  mode_on = count_on;
         default:  mode_on = 1'b0;
      endcase
   end

   always_comb begin
      d_ctx_in           = c_ctx_ff;
      d_ctx_in.normal_on = mode_on || c_ctx_ff.heartbeat_on || c_ctx_ff.traffic_on;
   end

   // ---------------- sequence pattern and result ----------------
   assign bat_pulses = battery_pulses(d_ctx_ff.seq_percent);

   always_comb begin
      seq_on = 1'b0;
      if (d_ctx_ff.seq_kind == SEQ_RESET) begin
         seq_on = reset_phase < SLOT_REM_W'(RESET_ON_MS);
      end else if (d_ctx_ff.seq_percent < 7'(BAT_LOW_PCT)) begin
         seq_on = d_ctx_ff.elapsed >= ELAPSED_W'(BAT_LEAD_MS)
                  && d_ctx_ff.elapsed < ELAPSED_W'(BAT_LEAD_MS + BAT_LOW_ON_MS);
      end else begin
         for (int k = 0; k < BAT_MAX_PULSES; k++) begin
            if (3'(k) < bat_pulses
                && d_ctx_ff.elapsed >= ELAPSED_W'(BAT_LEAD_MS + k * CNT_SLOT_MS)
                && d_ctx_ff.elapsed < ELAPSED_W'(BAT_LEAD_MS + k * CNT_SLOT_MS + CNT_ON_MS))
               seq_on = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_word_in               = '0;
      rsp_word_in.sequence_busy = d_ctx_ff.seq_kind != SEQ_NONE;
      rsp_word_in.led_pin       = (rsp_word_in.sequence_busy ? seq_on : d_ctx_ff.normal_on)
                                  ^ active_low_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_word_ff);

   // ---------------- checks ----------------
   `SLEDPG_ASSERT_IMP(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `SLEDPG_ASSERT_NXT(a_state_only_on_word, clock, reset, !state_step,
                      $stable(seq_kind_ff) && $stable(seq_start_ff) && $stable(traffic_pend_ff))
   `SLEDPG_ASSERT_IMP(a_seq_after_first_word, clock, reset, seq_kind_ff != SEQ_NONE, started_ff)

endmodule

[hdl/sledpg_cdiv.sv]
// Two-stage divider by a constant: reciprocal multiply, then one correction.
// Gives quotient parity and remainder. Standalone, no package use.
module sledpg_cdiv #(
   parameter int WIDTH   = 32,
   parameter int DIVISOR = 50,
   localparam int REM_W  = $clog2(DIVISOR)
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] dividend,
   output logic             quotient_odd,
   output logic [REM_W-1:0] remainder
);

   localparam int PROD_W = 2 * WIDTH;
   localparam logic [WIDTH-1:0] RECIP = WIDTH'((64'd1 << WIDTH) / 64'(DIVISOR));
   localparam logic [WIDTH-1:0] DIV_W = WIDTH'(DIVISOR);

   logic [PROD_W-1:0] product;
   logic [WIDTH-1:0]  est_ff;
   logic [WIDTH-1:0]  num_ff;
   logic [WIDTH-1:0]  back;
   logic [WIDTH-1:0]  resid;
   logic              fix;
   logic              odd_ff;
   logic [REM_W-1:0]  rem_ff;

   // estimate is the true quotient or one below it
   assign product = PROD_W'(dividend) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (enable) begin
         est_ff <= product[PROD_W-1:WIDTH];
         num_ff <= dividend;
      end
   end

   assign back  = est_ff * DIV_W;
   assign resid = num_ff - back;
   assign fix   = resid >= DIV_W;

   always_ff @(posedge clock) begin
      if (enable) begin
         odd_ff <= est_ff[0] ^ fix;
         rem_ff <= fix ? REM_W'(resid - DIV_W) : REM_W'(resid);
      end
   end

   assign quotient_odd = odd_ff;
   assign remainder    = rem_ff;

endmodule

[tb/tb_top.sv]
// Self-checking bench for status_led_pattern_generator: directed tick table, then random
// ticks over several register settings and idle profiles. Uses sledpg_pkg and the RTL only.
module tb_top;
   import sledpg_pkg::*;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   status_led_pattern_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("FAIL status_led_pattern_generator");
      $finish;
   end

   // predictor copy of registers and tick state
   logic [2:0]   model_mode = MODE_TRAFFIC;
   logic         model_hb = 1'b0;
   logic         model_al = 1'b0;
   seq_kind_type sq_kind = SEQ_NONE;
   logic [31:0]  sq_start = '0;
   logic [6:0]   sq_pct = '0;
   logic         bat_wait = 1'b0;
   logic [6:0]   bat_wait_pct = '0;
   logic         rst_wait = 1'b0;
   logic [31:0]  hb_ref = '0;
   logic [31:0]  hb_until = '0;
   logic [31:0]  trf_until = '0;
   logic         ticked = 1'b0;
   logic         trf_wait = 1'b0;

   rsp_word_type pending_leds [$];
   int           fault_count = 0;

   // typed expectation travels with the word it belongs to
   logic tick_known = 1'b0;
   logic tick_pin = 1'b0;
   logic tick_busy = 1'b0;

   int snd_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_starts = 0;
   int hold_seen = 0;
   int hold_left = 0;

   typedef struct {
      int unsigned mode, hb, al, now, ble, proxy, sta, ap;
      int unsigned trf, breq, pct, rreq, known, pin, busy;
   } tick_row_type;

   // mode hb al | now ble proxy sta ap | trf breq pct rreq | known pin busy
   tick_row_type dir_tab [26] = '{
      '{0, 0, 0, 0,            0,   0, 0,   0, 0, 0,   0, 0, 1, 0, 0},
      '{0, 0, 0, 1,            0,   0, 0,   0, 1, 0,   0, 0, 1, 1, 0},
      '{0, 0, 0, 51,           0,   0, 0,   0, 0, 0,   0, 0, 0, 0, 0},
      '{1, 0, 0, 100,          3,   0, 0,   0, 0, 0,   0, 0, 1, 1, 0},
      '{1, 0, 0, 150,          2,   0, 0,   0, 0, 0,   0, 0, 0, 0, 0},
      '{1, 0, 0, 1000,         1,   0, 0,   0, 0, 0,   0, 0, 0, 0, 0},
      '{1, 0, 0, 1001,         0,   0, 0,   0, 0, 0,   0, 0, 1, 0, 0},
      '{2, 0, 0, 1100,         0, 255, 0,   0, 0, 0,   0, 0, 1, 1, 0},
      '{2, 0, 0, 1101,         0,   0, 0,   0, 0, 0,   0, 0, 1, 0, 0},
      '{3, 0, 0, 1200,         0,   0, 1,   0, 0, 0,   0, 0, 1, 1, 0},
      '{3, 0, 0, 2500,         0,   0, 0,   0, 0, 0,   0, 0, 0, 0, 0},
      '{4, 0, 0, 3100,         0,   0, 0, 255, 0, 0,   0, 0, 0, 0, 0},
      '{4, 0, 0, 3400,         0,   0, 0,   1, 0, 0,   0, 0, 0, 0, 0},
      '{4, 0, 0, 3200,         0,   0, 0,   0, 0, 0,   0, 0, 1, 0, 0},
      '{7, 0, 0, 4000,         3, 255, 1, 255, 0, 0,   0, 0, 1, 0, 0},
      '{4, 1, 1, 10000,        0,   0, 0,   3, 0, 0,   0, 0, 0, 0, 0},
      '{4, 1, 1, 10010,        0,   0, 0,   3, 0, 0,   0, 0, 0, 0, 0},
      '{4, 1, 1, 20000,        0,   0, 0,   3, 0, 1, 127, 1, 0, 0, 0},
      '{4, 1, 1, 20050,        0,   0, 0,   3, 1, 0,   0, 0, 0, 0, 0},
      '{4, 1, 1, 22000,        0,   0, 0,   3, 0, 0,   0, 0, 0, 0, 0},
      '{4, 1, 1, 23100,        0,   0, 0,   3, 0, 0,   0, 0, 0, 0, 0},
      '{4, 1, 1, 0,            0,   0, 0,   3, 0, 0,   0, 0, 0, 0, 0},
      '{0, 0, 0, 100,          0,   0, 0,   0, 0, 1,   5, 0, 1, 0, 1},
      '{0, 0, 0, 1050,         0,   0, 0,   0, 0, 0,   0, 0, 0, 0, 0},
      '{0, 0, 0, 32'hFFFFFFFF, 0,   0, 0,   0, 0, 0,   0, 1, 1, 1, 1},
      '{0, 0, 0, 1,            0,   0, 0,   0, 0, 0,   0, 0, 0, 0, 0}
   };

   function automatic logic [31:0] pulse_count(input logic [6:0] pct);
      if (pct < 7'd25) return 32'd1;
      if (pct < 7'd50) return 32'd2;
      if (pct < 7'd75) return 32'd3;
      return 32'd4;
   endfunction

   function automatic logic [31:0] seq_span(input seq_kind_type k, input logic [6:0] pct);
      if (k == SEQ_RESET) return 32'(RESET_BLINKS * RESET_SLOT_MS);
      if (pct < 7'(BAT_LOW_PCT)) return 32'(BAT_LEAD_MS + BAT_LOW_BODY_MS + BAT_TAIL_MS);
      return 32'(BAT_LEAD_MS + BAT_TAIL_MS) + pulse_count(pct) * 32'(CNT_SLOT_MS);
   endfunction

   function automatic logic seq_lit(input seq_kind_type k, input logic [6:0] pct,
                                    input logic [31:0] e);
      logic [31:0] t;
      if (k == SEQ_RESET) return (e % 32'(RESET_SLOT_MS)) < 32'(RESET_ON_MS);
      if (e < 32'(BAT_LEAD_MS)) return 1'b0;
      t = e - 32'(BAT_LEAD_MS);
      if (pct < 7'(BAT_LOW_PCT)) return t < 32'(BAT_LOW_ON_MS);
      if (t >= pulse_count(pct) * 32'(CNT_SLOT_MS)) return 1'b0;
      return (t % 32'(CNT_SLOT_MS)) < 32'(CNT_ON_MS);
   endfunction

   function automatic logic half_lit(input logic [31:0] now, input logic [31:0] half);
      logic [31:0] q;
      q = now / half;
      return q[0];
   endfunction

   function automatic logic count_lit(input logic [31:0] now, input logic [7:0] stations);
      logic [31:0] n;
      logic [31:0] phase;
      n = (stations > 8'(MAX_COUNT_PULSES)) ? 32'(MAX_COUNT_PULSES) : 32'(stations);
      if (n == 32'd0) return 1'b0;
      phase = now % 32'(CNT_WINDOW_MS);
      if (phase >= n * 32'(CNT_SLOT_MS)) return 1'b0;
      return (phase % 32'(CNT_SLOT_MS)) < 32'(CNT_ON_MS);
   endfunction

   function automatic logic window_live(input logic [31:0] until_t, input logic [31:0] now);
      logic [31:0] d;
      d = until_t - now;
      return (d != 32'd0) && !d[31];
   endfunction

   function automatic logic mode_lit(input req_word_type w);
      case (model_mode)
         MODE_BLE: begin
            case (w.ble_state)
               BLE_CONNECTED:   return 1'b1;
               BLE_PAIRING:     return half_lit(w.now_ms, 32'(FAST_HALF_MS));
               BLE_ADVERTISING: return half_lit(w.now_ms, 32'(SLOW_HALF_MS));
               default:         return 1'b0;
            endcase
         end
         MODE_TCP: return w.proxy_clients != 8'd0;
         MODE_STA: return w.sta_connected || half_lit(w.now_ms, 32'(SLOW_HALF_MS));
         MODE_AP:  return count_lit(w.now_ms, w.ap_stations);
         default:  return 1'b0;
      endcase
   endfunction

   task automatic led_tick(input req_word_type w, output logic pin, output logic busy);
      logic [31:0] now;
      logic        lit;
      now = w.now_ms;
      if (w.reset_request) rst_wait = 1'b1;
      if (w.battery_request) begin
         bat_wait = 1'b1;
         bat_wait_pct = w.battery_percent;
      end
      if (w.traffic_seen) trf_wait = 1'b1;
      if (!ticked) begin
         ticked = 1'b1;
         hb_ref = now;
         hb_until = now;
         trf_until = now;
      end
      if (sq_kind != SEQ_NONE && (now - sq_start) >= seq_span(sq_kind, sq_pct))
         sq_kind = SEQ_NONE;
      if (sq_kind == SEQ_NONE) begin
         if (rst_wait) begin
            rst_wait = 1'b0;
            sq_kind = SEQ_RESET;
            sq_start = now;
         end else if (bat_wait) begin
            bat_wait = 1'b0;
            sq_kind = SEQ_BATTERY;
            sq_pct = bat_wait_pct;
            sq_start = now;
         end
      end
      if (sq_kind != SEQ_NONE) begin
         lit = seq_lit(sq_kind, sq_pct, now - sq_start);
      end else begin
         lit = mode_lit(w);
         if (model_hb) begin
            if ((now - hb_ref) >= 32'(HB_PERIOD_MS)) begin
               hb_ref = now;
               hb_until = now + 32'(HB_PULSE_MS);
            end
            if (window_live(hb_until, now)) lit = 1'b1;
         end
         if (trf_wait) begin
            trf_wait = 1'b0;
            trf_until = now + 32'(TRAFFIC_PULSE_MS);
         end
         if (window_live(trf_until, now)) lit = 1'b1;
      end
      pin = lit ^ model_al;
      busy = sq_kind != SEQ_NONE;
   endtask

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : watch_words
      rsp_word_type got;
      rsp_word_type want;
      logic         lit_pin;
      logic         lit_busy;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_leds.size() == 0) begin
               note_fault($sformatf("unexpected LED word %h", got));
            end else begin
               want = pending_leds.pop_front();
               if (got.led_pin !== want.led_pin || got.sequence_busy !== want.sequence_busy)
                  note_fault($sformatf("LED word mismatch: expected pin %b busy %b, got pin %b busy %b",
                                       want.led_pin, want.sequence_busy,
                                       got.led_pin, got.sequence_busy));
            end
         end
         if (req_tvalid && req_tready) begin
            led_tick(req_tdata, lit_pin, lit_busy);
            want = '0;
            want.led_pin = tick_known ? tick_pin : lit_pin;
            want.sequence_busy = tick_known ? tick_busy : lit_busy;
            pending_leds.push_back(want);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_starts != hold_seen) begin
         hold_seen = hold_starts;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic offer_word(input req_word_type w, input logic known, input logic pin,
                             input logic busy);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < snd_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      tick_known <= known;
      tick_pin <= pin;
      tick_busy <= busy;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_leds.size() != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic apply_config(input logic [2:0] mode, input logic hb, input logic al);
      csr_we <= 1'b1;
      csr_index <= CSR_LED_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      csr_index <= CSR_HB_ENABLE;
      csr_wdata <= {2'b00, hb};
      @(posedge clock);
      csr_index <= CSR_ACTIVE_LOW;
      csr_wdata <= {2'b00, al};
      @(posedge clock);
      csr_we <= 1'b0;
      model_mode = mode;
      model_hb = hb;
      model_al = al;
   endtask

   initial begin
      tick_row_type r;
      req_word_type w;
      logic [31:0]  now_t;
      int           roll;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      snd_idle_pct = 16;
      rsp_stall_pct = 16;
      for (int i = 0; i < 26; i++) begin
         r = dir_tab[i];
         if (r.mode != model_mode || r.hb != model_hb || r.al != model_al) begin
            drain();
            apply_config(3'(r.mode), 1'(r.hb), 1'(r.al));
         end
         w = '0;
         w.now_ms = r.now;
         w.ble_state = 2'(r.ble);
         w.proxy_clients = 8'(r.proxy);
         w.sta_connected = 1'(r.sta);
         w.ap_stations = 8'(r.ap);
         w.traffic_seen = 1'(r.trf);
         w.battery_request = 1'(r.breq);
         w.battery_percent = 7'(r.pct);
         w.reset_request = 1'(r.rreq);
         offer_word(w, 1'(r.known), 1'(r.pin), 1'(r.busy));
      end

      now_t = 32'd50000;
      for (int ph = 0; ph < 12; ph++) begin
         drain();
         apply_config(3'(ph % 8), (ph % 3) != 0, ((ph / 2) % 2) != 0);
         case (ph % 4)
            0: begin snd_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin snd_idle_pct = 74; rsp_stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  rsp_stall_pct = 74; end
            default: begin snd_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         if (ph == 4) hold_starts++;
         for (int k = 0; k < 40; k++) begin
            if (ph == 7 && k == 20) drain();
            roll = $urandom_range(0, 99);
            if (roll < 40) now_t += $urandom_range(0, 30);
            else if (roll < 92) now_t += $urandom_range(30, 300);
            else if (roll < 98) now_t += $urandom_range(2000, 12000);
            else now_t = $urandom;
            w = '0;
            w.now_ms = now_t;
            w.ble_state = 2'($urandom_range(0, 3));
            w.proxy_clients = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 2));
            w.sta_connected = 1'($urandom_range(0, 1));
            w.ap_stations = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 7));
            w.traffic_seen = $urandom_range(0, 99) < 15;
            w.battery_request = $urandom_range(0, 99) < 2;
            w.battery_percent = 7'($urandom_range(0, 127));
            w.reset_request = $urandom_range(0, 99) < 1;
            offer_word(w, 1'b0, 1'b0, 1'b0);
         end
      end
      drain();

      if (fault_count == 0)
         $display("PASS status_led_pattern_generator");
      else
         $display("FAIL status_led_pattern_generator");
      $finish;
   end

endmodule
